// ===== rtl/observer_pi_speed_control_assert.svh =====
// Assertion helpers for the observer PI speed controller.
// Both sample on the rising edge of clock and are off while reset is high.
`ifndef OBSERVER_PI_SPEED_CONTROL_ASSERT_SVH
`define OBSERVER_PI_SPEED_CONTROL_ASSERT_SVH

// Same-cycle implication.
`define OPSC_ASSERT_IMPL(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("opsc: same-cycle check failed");

// Next-cycle implication.
`define OPSC_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("opsc: next-cycle check failed");

`endif

// ===== rtl/opsc_pkg.sv =====
`timescale 1ns / 1ps

package opsc_pkg;

   localparam int SigWidth      = 32;
   localparam int CoefWidth     = 21;
   localparam int FracWidth     = 5;
   localparam int FracReset     = 16;
   localparam int MaxFrac       = CoefWidth - 1;
   localparam int CsrWidth      = 3 * CoefWidth;
   localparam int PiWidth       = 2 * CoefWidth;
   localparam int CsrIndexWidth = 3;
   localparam int NumTerms      = 5;
   // product plus growth of a five-term sum
   localparam int AccWidth      = SigWidth + CoefWidth + 3;

   typedef logic signed [SigWidth-1:0]  sig_type;
   typedef logic signed [CoefWidth-1:0] coef_type;
   typedef logic signed [AccWidth-1:0]  acc_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_B_COL     = 3'd0,
      CSR_A_ROW1    = 3'd1,
      CSR_A_ROW2    = 3'd2,
      CSR_A_ROW3    = 3'd3,
      CSR_GAIN_L    = 3'd4,
      CSR_PI        = 3'd5,
      CSR_FRAC_BITS = 3'd6
   } csr_index_type;

   typedef struct packed {
      sig_type speed_target;
      sig_type angle_meas;
      logic    restart;
   } req_type;

   typedef struct packed {
      sig_type torque_cmd;
      sig_type speed_est;
      sig_type load_est;
   } rsp_type;

   // Element [0] of each group is the lowest field of its register.
   typedef struct packed {
      logic [2:0][CoefWidth-1:0]      b;
      logic [2:0][2:0][CoefWidth-1:0] a;
      logic [2:0][CoefWidth-1:0]      l;
      coef_type                       kp;
      coef_type                       ki;
      logic [FracWidth-1:0]           frac;
   } coef_set_type;

   function automatic acc_type sext_sig(input sig_type v);
      return {{(AccWidth-SigWidth){v[SigWidth-1]}}, v};
   endfunction

   // Clamp a wide signed value to the signal range.
   function automatic sig_type sat_sig(input acc_type v);
      logic [AccWidth-SigWidth:0] hi_bits;
      sig_type                    result;
      hi_bits = v[AccWidth-1:SigWidth-1];
      if ((&hi_bits) || !(|hi_bits)) begin
         result = v[SigWidth-1:0];
      end else if (v[AccWidth-1]) begin
         result = {1'b1, {(SigWidth-1){1'b0}}};
      end else begin
         result = {1'b0, {(SigWidth-1){1'b1}}};
      end
      return result;
   endfunction

endpackage

// ===== rtl/opsc_csr.sv =====
`timescale 1ns / 1ps

module opsc_csr (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [opsc_pkg::CsrIndexWidth-1:0]      csr_index,
   input  logic [opsc_pkg::CsrWidth-1:0]           csr_data,
   output opsc_pkg::coef_set_type                  coef
);

   logic [opsc_pkg::CsrWidth-1:0]           b_col_ff, b_col_in;
   logic [2:0][opsc_pkg::CsrWidth-1:0]      a_row_ff, a_row_in;
   logic [opsc_pkg::CsrWidth-1:0]           gain_l_ff, gain_l_in;
   logic [opsc_pkg::PiWidth-1:0]            pi_ff, pi_in;
   logic [opsc_pkg::FracWidth-1:0]          frac_ff, frac_in;

   assign csr_ready = 1'b1;

   always_comb begin
      b_col_in  = b_col_ff;
      a_row_in  = a_row_ff;
      gain_l_in = gain_l_ff;
      pi_in     = pi_ff;
      frac_in   = frac_ff;
      if (csr_valid) begin
         unique case (csr_index)
            opsc_pkg::CSR_B_COL:     b_col_in    = csr_data;
            opsc_pkg::CSR_A_ROW1:    a_row_in[0] = csr_data;
            opsc_pkg::CSR_A_ROW2:    a_row_in[1] = csr_data;
            opsc_pkg::CSR_A_ROW3:    a_row_in[2] = csr_data;
            opsc_pkg::CSR_GAIN_L:    gain_l_in   = csr_data;
            opsc_pkg::CSR_PI:        pi_in       = csr_data[opsc_pkg::PiWidth-1:0];
            opsc_pkg::CSR_FRAC_BITS: frac_in     = csr_data[opsc_pkg::FracWidth-1:0];
            default: ;  // unmapped index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_col_ff  <= '0;
         a_row_ff  <= '0;
         gain_l_ff <= '0;
         pi_ff     <= '0;
         frac_ff   <= opsc_pkg::FracWidth'(opsc_pkg::FracReset);
      end else begin
         b_col_ff  <= b_col_in;
         a_row_ff  <= a_row_in;
         gain_l_ff <= gain_l_in;
         pi_ff     <= pi_in;
         frac_ff   <= frac_in;
      end
   end

   always_comb begin
      coef.b  = b_col_ff;
      coef.a  = a_row_ff;
      coef.l  = gain_l_ff;
      coef.kp = pi_ff[opsc_pkg::CoefWidth-1:0];
      coef.ki = pi_ff[opsc_pkg::PiWidth-1:opsc_pkg::CoefWidth];
      // shift is capped at one below the coefficient width
      if (frac_ff > opsc_pkg::FracWidth'(opsc_pkg::MaxFrac)) begin
         coef.frac = opsc_pkg::FracWidth'(opsc_pkg::MaxFrac);
      end else begin
         coef.frac = frac_ff;
      end
   end

endmodule

// ===== rtl/opsc_pi.sv =====
`timescale 1ns / 1ps

module opsc_pi (
   input  opsc_pkg::sig_type               target,
   input  opsc_pkg::sig_type               speed_held,
   input  opsc_pkg::sig_type               integral,
   input  opsc_pkg::sig_type               load_held,
   input  opsc_pkg::coef_type              kp,
   input  opsc_pkg::coef_type              ki,
   input  logic [opsc_pkg::FracWidth-1:0]  frac,
   output opsc_pkg::sig_type               torque,
   output opsc_pkg::sig_type               integral_next
);

   opsc_pkg::sig_type err;
   opsc_pkg::acc_type kp_prod;
   opsc_pkg::acc_type ki_prod;
   opsc_pkg::acc_type kp_term;
   opsc_pkg::acc_type ki_term;

   assign err = opsc_pkg::sat_sig(opsc_pkg::sext_sig(target) - opsc_pkg::sext_sig(speed_held));

   assign kp_prod = kp * err;
   assign ki_prod = ki * err;
   assign kp_term = kp_prod >>> frac;
   assign ki_term = ki_prod >>> frac;

   assign torque = opsc_pkg::sat_sig(kp_term + opsc_pkg::sext_sig(integral)
                                     + opsc_pkg::sext_sig(load_held));
   assign integral_next = opsc_pkg::sat_sig(ki_term + opsc_pkg::sext_sig(integral));

endmodule

// ===== rtl/opsc_obs_row.sv =====
`timescale 1ns / 1ps

// One row of the observer: b*torque + a1*pos + a2*speed + a3*load + l*eobs.
module opsc_obs_row (
   input  logic [opsc_pkg::NumTerms-1:0][opsc_pkg::CoefWidth-1:0] coef_row,
   input  logic [opsc_pkg::NumTerms-1:0][opsc_pkg::SigWidth-1:0]  operand,
   input  logic [opsc_pkg::FracWidth-1:0]                         frac,
   output opsc_pkg::sig_type                                      state_next
);

   opsc_pkg::coef_type c;
   opsc_pkg::sig_type  x;
   opsc_pkg::acc_type  sum;

   always_comb begin
      sum = '0;
      c   = '0;
      x   = '0;
      for (int k = 0; k < opsc_pkg::NumTerms; k++) begin
         c   = coef_row[k];
         x   = operand[k];
         sum = sum + c * x;
      end
   end

   assign state_next = opsc_pkg::sat_sig(sum >>> frac);

endmodule

// ===== rtl/observer_pi_speed_control.sv =====
`timescale 1ns / 1ps
// Observer-based PI speed controller, one control sample per request.
//
// req_*: speed target, measured angle and restart flag. A request with
//   restart set clears the observer, integrator and held values first.
// rsp_*: torque command plus the observer speed and load estimates as
//   they stood before this sample's update. One response per request,
//   in order.
// csr_*: coefficient writes by index, always ready; write only while idle.
//   Unmapped indexes are dropped.
//
// A request in the input register moves to the response register when
// that register is free. Throughput: one request per cycle while the
// receiver keeps up; a sample's PI and observer update is combinational
// from the input register into the state and response registers. If the
// receiver stalls, the response holds and one more request waits in the
// input register; req_ready then drops until the response drains.
// Reset: synchronous; clears the valid flags and the observer and PI
// state, zeroes coefficients and sets the fraction width to 16.
`include "observer_pi_speed_control_assert.svh"

module observer_pi_speed_control (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  opsc_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output opsc_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [opsc_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [opsc_pkg::CsrWidth-1:0]       csr_data
);

   opsc_pkg::coef_set_type coef;

   logic              in_valid_ff, in_valid_in;
   opsc_pkg::req_type in_data_ff, in_data_in;
   logic              rsp_valid_ff, rsp_valid_in;
   opsc_pkg::rsp_type rsp_data_ff, rsp_data_in;

   opsc_pkg::sig_type pos_ff, pos_in;
   opsc_pkg::sig_type speed_ff, speed_in;
   opsc_pkg::sig_type load_ff, load_in;
   opsc_pkg::sig_type speed_held_ff, speed_held_in;
   opsc_pkg::sig_type load_held_ff, load_held_in;
   opsc_pkg::sig_type integral_ff, integral_in;
   opsc_pkg::sig_type torque_held_ff, torque_held_in;

   logic              fire;
   logic              clr;
   opsc_pkg::sig_type pos_cur, speed_cur, load_cur;
   opsc_pkg::sig_type speed_held_cur, load_held_cur, integral_cur, torque_held_cur;
   opsc_pkg::sig_type eobs;
   opsc_pkg::sig_type torque, integral_next;
   opsc_pkg::sig_type obs_next [3];

   logic [2:0][opsc_pkg::NumTerms-1:0][opsc_pkg::CoefWidth-1:0] row_coef;
   logic [opsc_pkg::NumTerms-1:0][opsc_pkg::SigWidth-1:0]       row_operand;

   opsc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .coef      (coef)
   );

   // Handshake: the input register refills in the cycle its request fires.
   assign fire      = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // restart applies to the state seen by this request
   assign clr             = in_data_ff.restart;
   assign pos_cur         = clr ? '0 : pos_ff;
   assign speed_cur       = clr ? '0 : speed_ff;
   assign load_cur        = clr ? '0 : load_ff;
   assign speed_held_cur  = clr ? '0 : speed_held_ff;
   assign load_held_cur   = clr ? '0 : load_held_ff;
   assign integral_cur    = clr ? '0 : integral_ff;
   assign torque_held_cur = clr ? '0 : torque_held_ff;

   opsc_pi u_pi (
      .target        (in_data_ff.speed_target),
      .speed_held    (speed_held_cur),
      .integral      (integral_cur),
      .load_held     (load_held_cur),
      .kp            (coef.kp),
      .ki            (coef.ki),
      .frac          (coef.frac),
      .torque        (torque),
      .integral_next (integral_next)
   );

   assign eobs = opsc_pkg::sat_sig(opsc_pkg::sext_sig(in_data_ff.angle_meas)
                                   - opsc_pkg::sext_sig(pos_cur));

   // term order: previous torque, pos, speed, load, angle error
   assign row_operand = {eobs, load_cur, speed_cur, pos_cur, torque_held_cur};

   for (genvar i = 0; i < 3; i++) begin : g_row
      assign row_coef[i] = {coef.l[i], coef.a[i], coef.b[i]};

      opsc_obs_row u_row (
         .coef_row   (row_coef[i]),
         .operand    (row_operand),
         .frac       (coef.frac),
         .state_next (obs_next[i])
      );
   end

   always_comb begin
      in_valid_in    = req_ready ? req_valid : in_valid_ff;
      in_data_in     = (req_valid && req_ready) ? req_data : in_data_ff;
      rsp_valid_in   = fire || (rsp_valid_ff && !rsp_ready);
      rsp_data_in    = rsp_data_ff;
      pos_in         = pos_ff;
      speed_in       = speed_ff;
      load_in        = load_ff;
      speed_held_in  = speed_held_ff;
      load_held_in   = load_held_ff;
      integral_in    = integral_ff;
      torque_held_in = torque_held_ff;
      if (fire) begin
         rsp_data_in.torque_cmd = torque;
         rsp_data_in.speed_est  = speed_cur;
         rsp_data_in.load_est   = load_cur;
         pos_in                 = obs_next[0];
         speed_in               = obs_next[1];
         load_in                = obs_next[2];
         speed_held_in          = speed_cur;
         load_held_in           = load_cur;
         integral_in            = integral_next;
         torque_held_in         = torque;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         pos_ff         <= '0;
         speed_ff       <= '0;
         load_ff        <= '0;
         speed_held_ff  <= '0;
         load_held_ff   <= '0;
         integral_ff    <= '0;
         torque_held_ff <= '0;
      end else begin
         in_valid_ff    <= in_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         pos_ff         <= pos_in;
         speed_ff       <= speed_in;
         load_ff        <= load_in;
         speed_held_ff  <= speed_held_in;
         load_held_ff   <= load_held_in;
         integral_ff    <= integral_in;
         torque_held_ff <= torque_held_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   `OPSC_ASSERT_IMPL(a_stall_only_when_full, !req_ready, in_valid_ff && rsp_valid_ff && !rsp_ready)
   `OPSC_ASSERT_NEXT(a_restart_zero_est, fire && clr, rsp_valid_ff && rsp_data_ff.speed_est == '0 && rsp_data_ff.load_est == '0)
   `OPSC_ASSERT_NEXT(a_state_holds_idle, !fire, $stable(integral_ff) && $stable(pos_ff) && $stable(torque_held_ff))
   `OPSC_ASSERT_IMPL(a_torque_matches_held, rsp_valid_ff, rsp_data_ff.torque_cmd == torque_held_ff)

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import opsc_pkg::*;

   typedef logic [CsrWidth-1:0] csr_word;

   localparam int NumCsrs = int'(CSR_FRAC_BITS) + 1;
   localparam logic [CsrIndexWidth-1:0] CsrUnmapped = '1;
   localparam longint SigMaxL = (longint'(1) <<< (SigWidth - 1)) - 1;
   localparam longint SigMinL = -SigMaxL - 1;
   localparam sig_type SigMax = {1'b0, {(SigWidth-1){1'b1}}};
   localparam sig_type SigMin = {1'b1, {(SigWidth-1){1'b0}}};
   localparam coef_type CoefMax = {1'b0, {(CoefWidth-1){1'b1}}};
   localparam coef_type CoefMin = {1'b1, {(CoefWidth-1){1'b0}}};

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   req_type                  req_data;
   logic                     rsp_valid;
   logic                     rsp_ready;
   rsp_type                  rsp_data;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CsrIndexWidth-1:0] csr_index;
   csr_word                  csr_data;

   observer_pi_speed_control uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // controller mirror: coefficient registers plus observer and PI state
   csr_word coef_regs [NumCsrs];
   csr_word next_coefs [NumCsrs];
   longint  obs_pos, obs_speed, obs_load;
   longint  held_speed, held_load, held_torque, pi_integral;

   rsp_type pending_rsps [$];
   rsp_type rsp_want;

   int send_idle_pct;
   int rsp_stall_pct;
   int rsp_holdoff;
   int mismatch_count;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5000000;
      $display("observer_pi_speed_control regression: fail");
      $finish;
   end

   function automatic longint clamp_sig(input longint v);
      if (v > SigMaxL) return SigMaxL;
      if (v < SigMinL) return SigMinL;
      return v;
   endfunction

   function automatic longint coef_at(input int r, input int k);
      coef_type c;
      c = coef_regs[r][k*CoefWidth +: CoefWidth];
      return longint'(c);
   endfunction

   function automatic rsp_type advance_controller(input req_type item);
      longint  err, eobs, torque, acc;
      longint  next_state [3];
      sig_type tgt, ang;
      int      fb, row;
      rsp_type result;
      tgt = item.speed_target;
      ang = item.angle_meas;
      if (item.restart) begin
         obs_pos = 0;
         obs_speed = 0;
         obs_load = 0;
         held_speed = 0;
         held_load = 0;
         held_torque = 0;
         pi_integral = 0;
      end
      fb = int'(coef_regs[CSR_FRAC_BITS][FracWidth-1:0]);
      if (fb > MaxFrac) fb = MaxFrac;
      err = clamp_sig(longint'(tgt) - held_speed);
      torque = clamp_sig(((coef_at(CSR_PI, 0) * err) >>> fb) + pi_integral + held_load);
      pi_integral = clamp_sig(((coef_at(CSR_PI, 1) * err) >>> fb) + pi_integral);
      held_speed = obs_speed;
      held_load = obs_load;
      eobs = clamp_sig(longint'(ang) - obs_pos);
      // every row reads the state from before this update
      for (row = 0; row < 3; row++) begin
         acc = coef_at(CSR_B_COL, row) * held_torque
             + coef_at(CSR_A_ROW1 + row, 0) * obs_pos
             + coef_at(CSR_A_ROW1 + row, 1) * obs_speed
             + coef_at(CSR_A_ROW1 + row, 2) * obs_load
             + coef_at(CSR_GAIN_L, row) * eobs;
         next_state[row] = clamp_sig(acc >>> fb);
      end
      obs_pos = next_state[0];
      obs_speed = next_state[1];
      obs_load = next_state[2];
      held_torque = torque;
      result.torque_cmd = torque[SigWidth-1:0];
      result.speed_est = held_speed[SigWidth-1:0];
      result.load_est = held_load[SigWidth-1:0];
      return result;
   endfunction

   function automatic req_type make_req(input sig_type tgt, input sig_type ang,
                                        input logic restart);
      req_type r;
      r.speed_target = tgt;
      r.angle_meas = ang;
      r.restart = restart;
      return r;
   endfunction

   function automatic sig_type pick_sig();
      case ($urandom_range(7))
         0: return SigMax;
         1: return SigMin;
         2: return '0;
         3: return '1;
         4: return sig_type'($urandom_range(8191)) - sig_type'(4096);
         default: return sig_type'($urandom);
      endcase
   endfunction

   function automatic coef_type pick_coef();
      case ($urandom_range(5))
         0: return '0;
         1: return CoefMax;
         2: return CoefMin;
         3: return '1;
         default: return coef_type'($urandom);
      endcase
   endfunction

   function automatic coef_type minor_coef(input int fb);
      coef_type c;
      c = coef_type'($urandom_range(0, 1 << (fb - 3)));
      return $urandom_range(1) ? -c : c;
   endfunction

   function automatic csr_word pack3(input coef_type c0, input coef_type c1,
                                     input coef_type c2);
      return {c2, c1, c0};
   endfunction

   // roughly a plant model: integrating position, slowly decaying speed
   function automatic void build_plant_coefs();
      int       fb;
      coef_type unit;
      fb = $urandom_range(8, 16);
      unit = coef_type'(1 << fb);
      next_coefs[CSR_B_COL] = pack3(minor_coef(fb), minor_coef(fb), '0);
      next_coefs[CSR_A_ROW1] = pack3(unit, minor_coef(fb), '0);
      next_coefs[CSR_A_ROW2] = pack3('0, unit - coef_type'($urandom_range(0, 1 << (fb - 4))),
                                     minor_coef(fb));
      next_coefs[CSR_A_ROW3] = pack3('0, '0, unit);
      next_coefs[CSR_GAIN_L] = pack3(minor_coef(fb), minor_coef(fb), minor_coef(fb));
      next_coefs[CSR_PI] = csr_word'({minor_coef(fb), minor_coef(fb)});
      next_coefs[CSR_FRAC_BITS] = csr_word'(fb);
   endfunction

   function automatic void build_random_coefs();
      int i;
      for (i = 0; i < int'(CSR_FRAC_BITS); i++)
         next_coefs[i] = pack3(pick_coef(), pick_coef(), pick_coef());
      if ($urandom_range(1))
         next_coefs[CSR_FRAC_BITS] = csr_word'({$urandom, $urandom});
      else
         next_coefs[CSR_FRAC_BITS] = csr_word'($urandom_range(0, MaxFrac));
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 40)
         $display("%0t mismatch: %s", $realtime, msg);
   endtask

   task automatic set_idling(input int send_pct, input int stall_pct);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
   endtask

   // valid stays high after the request is taken; the next call with an idle gap or a drain lowers it
   task automatic send_sample(input req_type item);
      int gap;
      gap = 0;
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      pending_rsps.push_back(advance_controller(item));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_rsps.size() != 0);
   endtask

   task automatic write_csr(input logic [CsrIndexWidth-1:0] idx, input csr_word val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx < NumCsrs) coef_regs[idx] = val;
   endtask

   task automatic load_coefs();
      int i;
      wait_drained();
      for (i = 0; i < NumCsrs; i++) write_csr(CsrIndexWidth'(i), next_coefs[i]);
      csr_valid <= 1'b0;
   endtask

   task automatic run_trajectory(input int count);
      sig_type tgt, ang;
      int      n;
      tgt = sig_type'($urandom_range(0, 1 << 21)) - sig_type'(1 << 20);
      ang = sig_type'($urandom);
      for (n = 0; n < count; n++) begin
         if ($urandom_range(7) == 0)
            tgt = tgt + sig_type'($urandom_range(0, 1 << 16)) - sig_type'(1 << 15);
         ang = ang + (tgt >>> 4);
         send_sample(make_req(tgt, ang, n == 0 || $urandom_range(39) == 0));
      end
   endtask

   task automatic run_noise(input int count);
      int n;
      for (n = 0; n < count; n++)
         send_sample(make_req(pick_sig(), pick_sig(), $urandom_range(3) == 0));
   endtask

   // zero coefficients out of reset: torque and estimates stay at zero
   task automatic test_reset_state();
      set_idling(0, 0);
      send_sample(make_req(SigMax, SigMin, 1'b0));
      send_sample(make_req(SigMin, SigMax, 1'b1));
      send_sample(make_req('1, '0, 1'b0));
   endtask

   task automatic test_coef_extremes();
      int i;
      for (i = 0; i < int'(CSR_FRAC_BITS); i++)
         next_coefs[i] = pack3(CoefMax, CoefMax, CoefMax);
      next_coefs[CSR_FRAC_BITS] = '0;
      load_coefs();
      send_sample(make_req(SigMax, SigMin, 1'b1));
      send_sample(make_req(SigMin, SigMax, 1'b0));
      send_sample(make_req(SigMax, SigMax, 1'b0));
      // fraction width at or beyond the coefficient width clamps
      for (i = 0; i < int'(CSR_FRAC_BITS); i++)
         next_coefs[i] = pack3(CoefMin, CoefMin, CoefMin);
      next_coefs[CSR_FRAC_BITS] = csr_word'(31);
      load_coefs();
      send_sample(make_req(SigMin, SigMin, 1'b1));
      send_sample(make_req(SigMax, SigMin, 1'b0));
      send_sample(make_req('0, '1, 1'b0));
      next_coefs[CSR_FRAC_BITS] = csr_word'(MaxFrac + 1);
      load_coefs();
      send_sample(make_req(SigMax, '0, 1'b0));
      send_sample(make_req('1, SigMax, 1'b0));
   endtask

   task automatic test_unmapped_write();
      wait_drained();
      write_csr(CsrUnmapped, csr_word'({$urandom, $urandom}));
      csr_valid <= 1'b0;
      send_sample(make_req(sig_type'(1 << 16), SigMin, 1'b0));
      send_sample(make_req(SigMin, sig_type'(1 << 16), 1'b0));
   endtask

   task automatic test_restart_midrun();
      build_plant_coefs();
      load_coefs();
      send_sample(make_req(sig_type'(3 << 16), '0, 1'b1));
      send_sample(make_req(sig_type'(3 << 16), sig_type'(1 << 14), 1'b0));
      send_sample(make_req(sig_type'(3 << 16), sig_type'(1 << 15), 1'b0));
      send_sample(make_req(-sig_type'(2 << 16), sig_type'(1 << 16), 1'b0));
      send_sample(make_req(sig_type'(1 << 16), sig_type'(5 << 16), 1'b1));
      send_sample(make_req(sig_type'(1 << 16), sig_type'(5 << 16), 1'b0));
   endtask

   // receiver holds off while requests keep coming, so the input stalls
   task automatic test_backpressure();
      int n;
      build_plant_coefs();
      load_coefs();
      set_idling(0, 0);
      rsp_holdoff = 60;
      for (n = 0; n < 24; n++)
         send_sample(make_req(pick_sig(), pick_sig(), n == 0));
      wait_drained();
   endtask

   task automatic test_random_traffic();
      int phase, blk;
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: set_idling(0, 0);
            1: set_idling(66, 0);
            2: set_idling(0, 66);
            default: set_idling(29, 29);
         endcase
         for (blk = 0; blk < 5; blk++) begin
            if ($urandom_range(3) == 0) build_random_coefs();
            else build_plant_coefs();
            load_coefs();
            if ($urandom_range(3) == 0) run_noise(60);
            else run_trajectory(60);
         end
      end
   endtask

   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_holdoff > 0) begin
            rsp_ready <= 1'b0;
            rsp_holdoff--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsps.size() == 0) begin
            report_mismatch("response with no request outstanding");
         end else begin
            rsp_want = pending_rsps.pop_front();
            if (rsp_data.torque_cmd !== rsp_want.torque_cmd)
               report_mismatch($sformatf("torque_cmd got %0d want %0d",
                                         rsp_data.torque_cmd, rsp_want.torque_cmd));
            if (rsp_data.speed_est !== rsp_want.speed_est)
               report_mismatch($sformatf("speed_est got %0d want %0d",
                                         rsp_data.speed_est, rsp_want.speed_est));
            if (rsp_data.load_est !== rsp_want.load_est)
               report_mismatch($sformatf("load_est got %0d want %0d",
                                         rsp_data.load_est, rsp_want.load_est));
         end
      end
   end

   initial begin
      int i;
      mismatch_count = 0;
      rsp_holdoff = 0;
      set_idling(0, 0);
      for (i = 0; i < NumCsrs; i++) coef_regs[i] = '0;
      coef_regs[CSR_FRAC_BITS] = csr_word'(FracReset);
      obs_pos = 0;
      obs_speed = 0;
      obs_load = 0;
      held_speed = 0;
      held_load = 0;
      held_torque = 0;
      pi_integral = 0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_data <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_coef_extremes();
      test_unmapped_write();
      test_restart_midrun();
      test_backpressure();
      test_random_traffic();

      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("observer_pi_speed_control regression: pass");
      end else begin
         $display("observer_pi_speed_control regression: fail");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/opsc_pkg.sv
rtl/opsc_csr.sv
rtl/opsc_pi.sv
rtl/opsc_obs_row.sv
rtl/observer_pi_speed_control.sv
tb/tb_top.sv
